[rtl/dttn_pkg.sv]
// Types and constants shared by the decimal text parser.
// No dependencies.
package dttn_pkg;

  localparam int unsigned MANT_W = 48;
  localparam int unsigned FRAC_W = 6;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;

  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_SIGNED = 3'd1,
    PH_LOOK   = 3'd2,
    PH_BODY   = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic              negative;
    logic [MANT_W-1:0] magnitude;
    logic [FRAC_W-1:0] fraction_digits;
    status_e           status;
  } out_beat_t;

  typedef struct packed {
    phase_e            phase;
    logic [1:0]        look_step;
    logic              scan_open;
    logic              parse_open;
    logic [1:0]        sign_tally;
    logic              digit_seen;
    logic              letter_seen;
    logic              point_seen;
    logic [MANT_W-1:0] mant;
    logic [FRAC_W-1:0] frac_cnt;
    logic              minus_seen;
    logic              bad_form;
    logic              too_big;
  } parse_st_t;

  localparam parse_st_t PARSE_ST_RESET = '{
    phase:       PH_SPACE,
    look_step:   2'd0,
    scan_open:   1'b1,
    parse_open:  1'b1,
    sign_tally:  2'd0,
    digit_seen:  1'b0,
    letter_seen: 1'b0,
    point_seen:  1'b0,
    mant:        '0,
    frac_cnt:    '0,
    minus_seen:  1'b0,
    bad_form:    1'b0,
    too_big:     1'b0
  };

endpackage

[rtl/dttn_step.sv]
// Next-state and result logic for one character of the decimal text parser.
// Depends on dttn_pkg.
module dttn_step (
  input  dttn_pkg::in_beat_t  beat_i,
  input  dttn_pkg::parse_st_t st_i,
  output dttn_pkg::parse_st_t st_o,
  output dttn_pkg::out_beat_t res_o
);
  import dttn_pkg::*;

  logic [7:0]        c;
  logic              is_digit;
  logic              is_sign;
  logic              is_letter;
  logic              is_blank;
  logic [3:0]        dig;
  logic [MANT_W+3:0] prod;
  logic              run_val;
  logic              run_gat;
  logic              finish;
  parse_st_t         n;

  assign c         = beat_i.ch;
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_sign   = (c == CH_MINUS) || (c == CH_PLUS);
  assign is_letter = ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= CH_LC_A) && (c <= CH_LC_Z));
  assign is_blank  = (c == CH_SPACE) || (c == CH_TAB);
  assign dig       = 4'(c - CH_ZERO);
  // x*10 + d in four extra bits, compared against the saturation limit
  assign prod      = ({4'b0, st_i.mant} << 3) + ({4'b0, st_i.mant} << 1)
                   + {{MANT_W{1'b0}}, dig};

  always_comb begin
    n       = st_i;
    run_val = 1'b0;
    run_gat = 1'b0;
    finish  = 1'b0;

    if (st_i.phase != PH_DONE) begin
      if (c == CH_NUL) begin
        finish = 1'b1;
      end else begin
        finish = beat_i.last;
        case (st_i.phase)
          PH_SPACE: begin
            if (!is_blank) begin
              run_val = 1'b1;
              if (is_sign) begin
                n.minus_seen = (c == CH_MINUS);
                n.phase      = PH_SIGNED;
              end else begin
                run_gat = 1'b1;
                if (is_digit) begin
                  n.phase     = PH_LOOK;
                  n.look_step = 2'd1;
                end else begin
                  n.bad_form = 1'b1;
                  n.phase    = PH_BODY;
                end
              end
            end
          end
          PH_SIGNED: begin
            run_val = 1'b1;
            run_gat = 1'b1;
            if (!is_digit) n.bad_form = 1'b1;
            n.phase = PH_BODY;
          end
          PH_LOOK: begin
            run_val = 1'b1;
            run_gat = 1'b1;
            if (st_i.look_step == 2'd1) begin
              if (c == CH_POINT) begin
                n.look_step = 2'd2;
              end else begin
                if (!is_digit && c != CH_COMMA && c != CH_SPACE) n.bad_form = 1'b1;
                n.phase     = PH_BODY;
                n.look_step = 2'd0;
              end
            end else begin
              if (!is_digit) n.bad_form = 1'b1;
              n.phase     = PH_BODY;
              n.look_step = 2'd0;
            end
          end
          default: begin
            run_val = 1'b1;
            run_gat = 1'b1;
          end
        endcase

        if (run_val && st_i.scan_open) begin
          if (is_sign) begin
            if (st_i.sign_tally != 2'd2) n.sign_tally = st_i.sign_tally + 2'd1;
          end else if (is_digit) begin
            n.digit_seen = 1'b1;
          end else if (c == CH_POINT) begin
            n.scan_open = 1'b1;
          end else if (is_letter) begin
            n.letter_seen = 1'b1;
          end else begin
            n.scan_open = 1'b0;
          end
        end

        if (run_gat && st_i.parse_open) begin
          if (is_digit) begin
            if (prod > {4'b0, {MANT_W{1'b1}}}) begin
              n.mant    = '1;
              n.too_big = 1'b1;
            end else begin
              n.mant = prod[MANT_W-1:0];
            end
            if (st_i.point_seen) begin
              if (st_i.frac_cnt == {FRAC_W{1'b1}}) n.too_big  = 1'b1;
              else                                 n.frac_cnt = st_i.frac_cnt + FRAC_W'(1);
            end
          end else if (c == CH_POINT && !st_i.point_seen) begin
            n.point_seen = 1'b1;
          end else begin
            n.parse_open = 1'b0;
          end
        end
      end

      if (finish) begin
        if (n.phase == PH_SPACE || n.phase == PH_SIGNED ||
            (n.phase == PH_LOOK && n.look_step == 2'd2)) begin
          n.bad_form = 1'b1;
        end
        if (!n.digit_seen || n.sign_tally > 2'd1 || n.letter_seen) n.bad_form = 1'b1;
        n.phase = PH_DONE;
      end
    end

    if (n.bad_form) begin
      res_o.negative        = 1'b0;
      res_o.magnitude       = '0;
      res_o.fraction_digits = '0;
      res_o.status          = ST_MALFORMED;
    end else begin
      res_o.negative        = n.minus_seen;
      res_o.magnitude       = n.mant;
      res_o.fraction_digits = n.frac_cnt;
      res_o.status          = n.too_big ? ST_OVERFLOW : ST_OK;
    end

    st_o = beat_i.last ? PARSE_ST_RESET : n;
  end

endmodule

[rtl/decimal_text_to_number.sv]
// Top level of the decimal text parser: input register, parse state, result register.
// Depends on dttn_pkg and dttn_step.
//
// Takes one ASCII character per beat, the beat with last set closing the text, and
// gives one result beat per text: sign, 48-bit decimal mantissa, digits after the
// point and a status (valid, malformed, overflow). A character beat may enter every
// cycle unless in_stall_o is set; a result loads as its last beat advances. The only
// loop is the parse state register, updated by one multiply-by-ten accumulate per
// character. A last beat waits only while an earlier result is held by out_stall_i.
module decimal_text_to_number (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dttn_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dttn_pkg::out_beat_t out_beat_o
);
  import dttn_pkg::*;

  in_beat_t  item_q;
  logic      item_vld_q;
  parse_st_t st_q;
  parse_st_t st_d;
  out_beat_t res_d;
  out_beat_t res_q;
  logic      res_vld_q;
  logic      advance;

  assign advance    = item_vld_q && !(item_q.last && res_vld_q && out_stall_i);
  assign in_stall_o = item_vld_q && !advance;

  dttn_step u_step (
    .beat_i (item_q),
    .st_i   (st_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      st_q       <= PARSE_ST_RESET;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        item_vld_q <= 1'b1;
      end else if (advance) begin
        item_vld_q <= 1'b0;
      end
      if (advance) begin
        st_q <= st_d;
      end
      if (advance && item_q.last) begin
        res_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_beat_i;
    end
    if (advance && item_q.last) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_beat_o  = res_q;

  a_res_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_vld_q) |-> $past(item_vld_q && item_q.last))
    else $error("result beat without a last character");

  a_malformed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.status == ST_MALFORMED) |->
      (out_beat_o.magnitude == '0 && !out_beat_o.negative &&
       out_beat_o.fraction_digits == '0))
    else $error("malformed result carries a value");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.last) |=> (st_q == PARSE_ST_RESET))
    else $error("parse state not cleared after last character");

endmodule
